@@ src/pftb_pkg.sv @@
`default_nettype none

package pftb_pkg;

  // input item kinds
  localparam logic [1:0] KIND_CONSUME = 2'd0;
  localparam logic [1:0] KIND_SET     = 2'd1;
  localparam logic [1:0] KIND_RESET   = 2'd2;

  // configuration register select, paddr[2]
  localparam logic REG_DEFAULT_RATE  = 1'b0;
  localparam logic REG_DEFAULT_BURST = 1'b1;

  localparam logic [15:0] MS_PER_MIN   = 16'd60000;
  localparam logic [15:0] IDLE_WAIT_MS = 16'd1000;
  localparam logic [15:0] RATE_RESET   = 16'd60;
  localparam logic [15:0] BURST_RESET  = 16'd10;

  // flow index widened so that it compares against any table size
  localparam int unsigned FLOW_EXT_W = 13;

  // wait length divider, 60000 / rate
  localparam int unsigned DIV_W     = 16;
  localparam int unsigned DIV_CNT_W = 5;
  localparam logic [DIV_CNT_W-1:0] PER_ITERS = 5'd16;

  // refill divide: x * 65536 / 60000 == (x << 11) / 1875
  localparam logic [27:0] REFILL_DIVISOR = 28'd1875;
  localparam logic [27:0] REFILL_RECIP   = 28'd146601551;  // ceil(2^38 / 1875)
  localparam logic [3:0]  REFILL_STEPS   = 4'd8;

  typedef struct packed {
    logic clr_wr;
    logic item_load;
    logic mem_rd;
    logic load;
    logic mul;
    logic refill_start;
    logic refill_apply;
    logic per_start;
    logic per_capture;
    logic per_idle;
    logic take;
    logic wait_set;
    logic wb;
    logic out_load;
  } pftb_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic consume;
    logic t_behind;
    logic div_done;
    logic has_token;
    logic rate_zero;
    logic wait_zero;
  } pftb_sts_t;

endpackage

`default_nettype wire

@@ src/pftb_div.sv @@
`default_nettype none

module pftb_div (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [pftb_pkg::DIV_W-1:0] dividend_i,
  input  wire logic [15:0]                divisor_i,
  input  wire logic [pftb_pkg::DIV_CNT_W-1:0] iters_i,
  output logic                            done_o,
  output logic [pftb_pkg::DIV_W-1:0]      quotient_o
);
  import pftb_pkg::*;

  logic [DIV_W-1:0]     acc_q;
  logic [15:0]          rem_q;
  logic [15:0]          dvs_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 done_q;
  logic [16:0]          shifted;
  logic                 ge;
  logic [16:0]          diff;

  // restoring division, one quotient bit a cycle; quotient bits enter at the bottom
  assign shifted = {rem_q, acc_q[DIV_W-1]};
  assign ge      = shifted >= {1'b0, dvs_q};
  assign diff    = shifted - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= iters_i;
      done_q <= 1'b0;
    end else begin
      done_q <= (cnt_q == DIV_CNT_W'(1));
      if (cnt_q != '0) cnt_q <= cnt_q - DIV_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (cnt_q != '0) begin
      acc_q <= {acc_q[DIV_W-2:0], ge};
      rem_q <= ge ? diff[15:0] : shifted[15:0];
    end
  end

  assign done_o     = done_q;
  assign quotient_o = acc_q;

endmodule

// refill divide by 60000 of x * 65536, 16-bit digits from the top; for each digit:
// multiply by the reciprocal, then take the digit and the remainder
module pftb_rdiv (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [47:0] prod_i,
  output logic             done_o,
  output logic [63:0]      quotient_o
);
  import pftb_pkg::*;

  logic [63:0] num_q;
  logic [10:0] rem_q;
  logic [15:0] qd_q;
  logic [63:0] quo_q;
  logic [3:0]  cnt_q;
  logic        done_q;
  logic [26:0] part;
  logic [54:0] prod_full;
  logic [27:0] back;
  logic [27:0] left;

  // part < 1875 * 65536, so the shifted product is the exact digit
  assign part      = {rem_q, num_q[63:48]};
  assign prod_full = {28'b0, part} * {27'b0, REFILL_RECIP};
  assign back      = {12'b0, qd_q} * REFILL_DIVISOR;
  assign left      = {1'b0, part} - back;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= REFILL_STEPS;
      done_q <= 1'b0;
    end else begin
      done_q <= (cnt_q == 4'd1);
      if (cnt_q != '0) cnt_q <= cnt_q - 4'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= {5'b0, prod_i, 11'b0};
      rem_q <= '0;
    end else if (cnt_q != '0) begin
      if (!cnt_q[0]) begin
        qd_q <= prod_full[53:38];
      end else begin
        rem_q <= left[10:0];
        quo_q <= {quo_q[47:0], qd_q};
        num_q <= {num_q[47:0], 16'b0};
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

@@ src/pftb_dp.sv @@
`default_nettype none

module pftb_dp #(
  parameter int unsigned NUM_FLOWS = 64
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire pftb_pkg::pftb_cmd_t cmd_i,
  output pftb_pkg::pftb_sts_t      sts_o,
  input  wire logic [15:0]         def_rate_i,
  input  wire logic [15:0]         def_burst_i,
  input  wire logic [1:0]          kind_i,
  input  wire logic [5:0]          flow_i,
  input  wire logic [31:0]         now_ms_i,
  input  wire logic [15:0]         timeout_ms_i,
  input  wire logic [15:0]         rate_i,
  input  wire logic [15:0]         burst_i,
  output logic                     granted_o,
  output logic [15:0]              wait_ms_o,
  output logic [15:0]              tokens_whole_o
);
  import pftb_pkg::*;

  localparam int unsigned IDX_W = (NUM_FLOWS > 1) ? $clog2(NUM_FLOWS) : 1;

  typedef struct packed {
    logic        valid;
    logic [15:0] rate;
    logic [15:0] burst;
    logic [31:0] tokens;
    logic [31:0] last;
  } entry_t;

  entry_t mem [NUM_FLOWS];
  entry_t rd_q;
  entry_t wdata;
  logic   we;
  logic [IDX_W-1:0] waddr;
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] clr_addr_q;

  // item beat
  logic [1:0]  kind_q;
  logic [5:0]  flow_q;
  logic [31:0] now_q;
  logic [15:0] tmo_q;
  logic [15:0] rate_in_q;
  logic [15:0] burst_in_q;

  // working copy of the bucket
  logic [15:0] rate_q;
  logic [15:0] burst_q;
  logic [31:0] tokens_q;
  logic [31:0] last_q;
  logic [31:0] t_q;
  logic [47:0] prod_q;
  logic [15:0] per_q;
  logic [15:0] wait_q;
  logic        granted_q;
  logic [15:0] whole_q;

  logic        out_granted_q;
  logic [15:0] out_wait_q;
  logic [15:0] out_whole_q;

  logic [FLOW_EXT_W-1:0] flow_ext;
  logic        in_range;
  logic [31:0] elapsed;
  logic [15:0] wait_min;
  logic [32:0] t_sum;
  logic [31:0] cap;
  logic [32:0] sum;
  logic        sat;

  logic             div_done;
  logic [DIV_W-1:0] quo;
  logic             rdiv_done;
  logic [63:0]      rquo;

  assign flow_ext = {{(FLOW_EXT_W-6){1'b0}}, flow_q};
  assign idx      = flow_ext[IDX_W-1:0];
  assign in_range = flow_ext < FLOW_EXT_W'(NUM_FLOWS);

  assign elapsed  = t_q - last_q;
  assign wait_min = (tmo_q < per_q) ? tmo_q : per_q;
  assign t_sum    = {1'b0, now_q} + {17'b0, wait_min};

  assign cap = {burst_q, 16'b0};
  assign sum = {1'b0, tokens_q} + {1'b0, rquo[31:0]};
  assign sat = (rquo[63:32] != '0) || (sum >= {1'b0, cap});

  // memory write port: clearing sweep, set/reset at load, write-back
  always_comb begin
    we    = 1'b0;
    waddr = idx;
    wdata = '0;
    if (cmd_i.clr_wr) begin
      we    = 1'b1;
      waddr = clr_addr_q;
    end else if (cmd_i.load && in_range && kind_q == KIND_SET) begin
      we    = 1'b1;
      wdata = '{valid: 1'b1, rate: rate_in_q, burst: burst_in_q,
                tokens: {burst_in_q, 16'b0}, last: now_q};
    end else if (cmd_i.load && in_range && kind_q == KIND_RESET) begin
      we = 1'b1;
    end else if (cmd_i.wb) begin
      we    = 1'b1;
      wdata = '{valid: 1'b1, rate: rate_q, burst: burst_q, tokens: tokens_q, last: last_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    if (cmd_i.mem_rd) rd_q <= mem[idx];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
    end else if (cmd_i.clr_wr) begin
      clr_addr_q <= clr_addr_q + IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.item_load) begin
      kind_q     <= kind_i;
      flow_q     <= flow_i;
      now_q      <= now_ms_i;
      tmo_q      <= timeout_ms_i;
      rate_in_q  <= rate_i;
      burst_in_q <= burst_i;
    end

    if (cmd_i.load) begin
      granted_q <= 1'b0;
      wait_q    <= '0;
      whole_q   <= (in_range && kind_q == KIND_SET) ? burst_in_q : '0;
      t_q       <= now_q;
      if (rd_q.valid) begin
        rate_q   <= rd_q.rate;
        burst_q  <= rd_q.burst;
        tokens_q <= rd_q.tokens;
        last_q   <= rd_q.last;
      end else begin
        // miss: fresh full bucket from the defaults
        rate_q   <= def_rate_i;
        burst_q  <= def_burst_i;
        tokens_q <= {def_burst_i, 16'b0};
        last_q   <= now_q;
      end
    end

    if (cmd_i.mul) prod_q <= {32'b0, rate_q} * {16'b0, elapsed};

    // refill only moves the stamp when something was added
    if (cmd_i.refill_apply && rquo != '0) begin
      tokens_q <= sat ? cap : sum[31:0];
      last_q   <= t_q;
    end

    if (cmd_i.take && tokens_q[31:16] != '0) begin
      tokens_q[31:16] <= tokens_q[31:16] - 16'd1;
      granted_q       <= 1'b1;
    end

    if (cmd_i.per_capture) per_q <= quo;
    if (cmd_i.per_idle)    per_q <= IDLE_WAIT_MS;

    if (cmd_i.wait_set) begin
      wait_q <= wait_min;
      t_q    <= t_sum[32] ? '1 : t_sum[31:0];
    end

    if (cmd_i.wb) whole_q <= tokens_q[31:16];

    if (cmd_i.out_load) begin
      out_granted_q <= granted_q;
      out_wait_q    <= wait_q;
      out_whole_q   <= whole_q;
    end
  end

  pftb_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.per_start),
    .dividend_i (MS_PER_MIN),
    .divisor_i  (rate_q),
    .iters_i    (PER_ITERS),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  pftb_rdiv u_rdiv (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.refill_start),
    .prod_i     (prod_q),
    .done_o     (rdiv_done),
    .quotient_o (rquo)
  );

  assign sts_o.clr_last  = clr_addr_q == IDX_W'(NUM_FLOWS - 1);
  assign sts_o.consume   = in_range && kind_q == KIND_CONSUME;
  assign sts_o.t_behind  = t_q < last_q;
  assign sts_o.div_done  = div_done || rdiv_done;
  assign sts_o.has_token = tokens_q[31:16] != '0;
  assign sts_o.rate_zero = rate_q == '0;
  assign sts_o.wait_zero = wait_min == '0;

  assign granted_o      = out_granted_q;
  assign wait_ms_o      = out_wait_q;
  assign tokens_whole_o = out_whole_q;

endmodule

`default_nettype wire

@@ src/pftb_ctrl.sv @@
`default_nettype none

module pftb_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output pftb_pkg::pftb_cmd_t      cmd_o,
  input  wire pftb_pkg::pftb_sts_t sts_i
);
  import pftb_pkg::*;

  typedef enum logic [11:0] {
    S_CLEAR   = 12'b0000_0000_0001,
    S_IDLE    = 12'b0000_0000_0010,
    S_READ    = 12'b0000_0000_0100,
    S_LOAD    = 12'b0000_0000_1000,
    S_MUL     = 12'b0000_0001_0000,
    S_DIVGO   = 12'b0000_0010_0000,
    S_DIVW    = 12'b0000_0100_0000,
    S_TAKE    = 12'b0000_1000_0000,
    S_PERW    = 12'b0001_0000_0000,
    S_WAITSEL = 12'b0010_0000_0000,
    S_WB      = 12'b0100_0000_0000,
    S_DONE    = 12'b1000_0000_0000
  } state_e;

  state_e state_q, state_d;
  logic   phase_q, phase_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = state_q != S_IDLE;

  always_comb begin
    cmd_o       = '0;
    state_d     = state_q;
    phase_d     = phase_q;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.item_load = 1'b1;
          state_d         = S_READ;
        end
      end
      S_READ: begin
        cmd_o.mem_rd = 1'b1;
        state_d      = S_LOAD;
      end
      S_LOAD: begin
        cmd_o.load = 1'b1;
        phase_d    = 1'b0;
        state_d    = sts_i.consume ? S_MUL : S_DONE;
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        // clock behind the stamp: no refill
        state_d   = sts_i.t_behind ? S_TAKE : S_DIVGO;
      end
      S_DIVGO: begin
        cmd_o.refill_start = 1'b1;
        state_d            = S_DIVW;
      end
      S_DIVW: begin
        if (sts_i.div_done) begin
          cmd_o.refill_apply = 1'b1;
          state_d            = S_TAKE;
        end
      end
      S_TAKE: begin
        cmd_o.take = 1'b1;
        if (sts_i.has_token || phase_q) begin
          state_d = S_WB;
        end else if (sts_i.rate_zero) begin
          cmd_o.per_idle = 1'b1;
          state_d        = S_WAITSEL;
        end else begin
          cmd_o.per_start = 1'b1;
          state_d         = S_PERW;
        end
      end
      S_PERW: begin
        if (sts_i.div_done) begin
          cmd_o.per_capture = 1'b1;
          state_d           = S_WAITSEL;
        end
      end
      S_WAITSEL: begin
        cmd_o.wait_set = 1'b1;
        if (sts_i.wait_zero) begin
          state_d = S_WB;
        end else begin
          phase_d = 1'b1;
          state_d = S_MUL;
        end
      end
      S_WB: begin
        cmd_o.wb = 1'b1;
        state_d  = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      phase_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

@@ src/per_flow_token_bucket.sv @@
// Set-rate, reset, unknown and out-of-range beats go from the table read straight to the
// result; a consume refills, tries to take a token and, failing that, sets the wait and,
// unless it is zero, retries once (refill divide at most twice, wait-length divide once).
// Throughput: one beat at a time, taken again in the cycle after the result is loaded, even
// while it waits. Reset: the bucket table is swept invalid entry by entry with input
// stalled; default_rate resets to 60, default_burst to 10.
`default_nettype none

module per_flow_token_bucket #(
  parameter int unsigned NUM_FLOWS = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,

  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,

  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  kind_i,
  input  wire logic [5:0]  flow_i,
  input  wire logic [31:0] now_ms_i,
  input  wire logic [15:0] timeout_ms_i,
  input  wire logic [15:0] rate_i,
  input  wire logic [15:0] burst_i,

  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             granted_o,
  output logic [15:0]      wait_ms_o,
  output logic [15:0]      tokens_whole_o
);
  import pftb_pkg::*;

  logic [15:0] def_rate_q;
  logic [15:0] def_burst_q;
  logic        cfg_wr;
  pftb_cmd_t   cmd;
  pftb_sts_t   sts;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      def_rate_q  <= RATE_RESET;
      def_burst_q <= BURST_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_DEFAULT_RATE)  def_rate_q  <= pwdata[15:0];
      if (paddr[2] == REG_DEFAULT_BURST) def_burst_q <= pwdata[15:0];
    end
  end

  assign prdata = {16'b0, (paddr[2] == REG_DEFAULT_BURST) ? def_burst_q : def_rate_q};

  pftb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  pftb_dp #(
    .NUM_FLOWS (NUM_FLOWS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .def_rate_i     (def_rate_q),
    .def_burst_i    (def_burst_q),
    .kind_i         (kind_i),
    .flow_i         (flow_i),
    .now_ms_i       (now_ms_i),
    .timeout_ms_i   (timeout_ms_i),
    .rate_i         (rate_i),
    .burst_i        (burst_i),
    .granted_o      (granted_o),
    .wait_ms_o      (wait_ms_o),
    .tokens_whole_o (tokens_whole_o)
  );

endmodule

`default_nettype wire
